// ----- hw/rtl/passive_reply_address_parser_top_macros.svh -----
// Assertion macros used by the passive reply address parser checker.
`ifndef PASSIVE_REPLY_ADDRESS_PARSER_TOP_MACROS_SVH
`define PASSIVE_REPLY_ADDRESS_PARSER_TOP_MACROS_SVH

// Check a property at every rising edge, reset included.
`define PRAP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property at every rising edge outside reset.
`define PRAP_ASSERT_ACTIVE(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ----- hw/rtl/prap_pkg.sv -----
// Shared types and character constants of the passive reply address parser.
package prap_pkg;

   localparam int BYTE_W  = 8;
   localparam int ADDR_W  = 32;
   localparam int PORT_W  = 16;
   localparam int FIELD_W = 10;
   localparam int COUNT_W = 2;

   localparam logic [BYTE_W-1:0]  CHAR_OPEN    = 8'h28;  // '('
   localparam logic [BYTE_W-1:0]  CHAR_COMMA   = 8'h2C;  // ','
   localparam logic [BYTE_W-1:0]  CHAR_NEWLINE = 8'h0A;  // '\n'
   localparam logic [BYTE_W-1:0]  CHAR_ZERO    = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0]  CHAR_NINE    = 8'h39;  // '9'

   localparam logic [FIELD_W-1:0] BYTE_MAX     = 10'd255;
   localparam logic [COUNT_W-1:0] MAX_DIGITS   = 2'd3;

   // One received character held between the input register and the parser
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] rx_byte;
   } prap_stage_type;

endpackage

// ----- hw/rtl/prap_if.sv -----
// Valid/ready channel interfaces for reply characters and parsed addresses.
interface prap_req_if
   import prap_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface prap_rsp_if
   import prap_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] host_addr;
   logic [PORT_W-1:0] data_port;
   logic              out_of_range;

   modport source (output valid, output host_addr, output data_port, output out_of_range,
                   input ready);
   modport sink   (input valid, input host_addr, input data_port, input out_of_range,
                   output ready);
endinterface

// ----- hw/rtl/prap_input_stage.sv -----
// Input register that holds one reply character until the parser takes it.
module prap_input_stage
   import prap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   prap_req_if.sink       req_bus,
   input  logic           take,
   output prap_stage_type stage
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              accept;

   // Accept a beat when the register is empty or drains this cycle
   assign req_bus.ready = !valid_ff || take;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture the character on each accepted beat
   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_bus.rx_byte;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

// ----- hw/rtl/prap_parser.sv -----
// Reply parser state and the result register that drives the response channel.
module prap_parser
   import prap_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  prap_stage_type stage,
   output logic           take,
   prap_rsp_if.source     rsp_bus
);

   typedef enum logic [2:0] {
      PH_WAIT = 3'd0,
      PH_NUM1 = 3'd1,
      PH_NUM2 = 3'd2,
      PH_NUM3 = 3'd3,
      PH_NUM4 = 3'd4,
      PH_NUM5 = 3'd5,
      PH_NUM6 = 3'd6
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [FIELD_W-1:0] field_ff, field_in;
   logic [ADDR_W-1:0]  host_ff, host_in;
   logic [BYTE_W-1:0]  port_high_ff, port_high_in;
   logic               range_ff, range_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  rsp_host_ff;
   logic [PORT_W-1:0]  rsp_port_ff;
   logic               rsp_range_ff;

   logic               reading, is_open, is_digit, is_comma, is_newline;
   logic               emits, out_free, load;
   logic [3:0]         digit;
   logic [BYTE_W-1:0]  sat_value;
   logic               over;

   // Classify the held character
   always_comb begin
      reading    = (phase_ff inside {[PH_NUM1:PH_NUM6]});
      is_open    = (stage.rx_byte == CHAR_OPEN);
      is_digit   = (stage.rx_byte inside {[CHAR_ZERO:CHAR_NINE]});
      is_comma   = (stage.rx_byte == CHAR_COMMA);
      is_newline = (stage.rx_byte == CHAR_NEWLINE);
      digit      = 4'(stage.rx_byte - CHAR_ZERO);
   end

   // Saturate the number in progress to one byte
   assign over      = (field_ff > BYTE_MAX);
   assign sat_value = over ? BYTE_MAX[BYTE_W-1:0] : field_ff[BYTE_W-1:0];

   // Only the closing newline needs a free result slot
   assign emits    = reading && (phase_ff == PH_NUM6) && is_newline;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign take     = stage.valid && (!emits || out_free);
   assign load     = take && emits;

   // Advance the parse state on the character taken
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      field_in     = field_ff;
      host_in      = host_ff;
      port_high_in = port_high_ff;
      range_in     = range_ff;
      if (take) begin
         if (!reading) begin
            if (is_open) begin
               phase_in     = PH_NUM1;
               count_in     = '0;
               field_in     = '0;
               host_in      = '0;
               port_high_in = '0;
               range_in     = 1'b0;
            end
         end else if (is_digit) begin
            if (count_ff < MAX_DIGITS) begin
               field_in = FIELD_W'((field_ff << 3) + (field_ff << 1) + {6'd0, digit});
               count_in = count_ff + 2'd1;
            end
         end else if (is_comma && (phase_ff != PH_NUM6)) begin
            count_in = '0;
            field_in = '0;
            range_in = range_ff | over;
            if (phase_ff inside {[PH_NUM1:PH_NUM4]}) begin
               host_in = {host_ff[ADDR_W-BYTE_W-1:0], sat_value};
            end else begin
               port_high_in = sat_value;
            end
            phase_in = phase_type'(phase_ff + 3'd1);
         end else if (emits) begin
            phase_in     = PH_WAIT;
            count_in     = '0;
            field_in     = '0;
            host_in      = '0;
            port_high_in = '0;
            range_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         count_ff     <= '0;
         field_ff     <= '0;
         host_ff      <= '0;
         port_high_ff <= '0;
         range_ff     <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         field_ff     <= field_in;
         host_ff      <= host_in;
         port_high_ff <= port_high_in;
         range_ff     <= range_in;
      end
   end

   // Hold the result until the sink takes the beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_host_ff  <= host_ff;
         rsp_port_ff  <= {port_high_ff, sat_value};
         rsp_range_ff <= range_ff | over;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.host_addr    = rsp_host_ff;
   assign rsp_bus.data_port    = rsp_port_ff;
   assign rsp_bus.out_of_range = rsp_range_ff;

endmodule

// ----- hw/rtl/passive_reply_address_parser_top.sv -----
// Top level of the passive-mode reply address parser.
//
//   channel  dir  beat payload                        handshake
//   req_bus  in   rx_byte[7:0]                        valid/ready
//   rsp_bus  out  host_addr[31:0], data_port[15:0],   valid/ready
//                 out_of_range
//
// One character per cycle is accepted while no stalled result blocks a newline; the
// parse state updates in one step. A result is registered in the output register.
// Synchronous reset clears the parse state and both valid registers; no clearing pass.
// A stalled result holds back only a closing newline; that newline waits in the input
// register and no further character is accepted until the result beat is taken.
module passive_reply_address_parser_top
   import prap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   prap_req_if.sink    req_bus,
   prap_rsp_if.source  rsp_bus
);

   prap_stage_type stage;
   logic           take;

   prap_input_stage u_input_stage (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .stage   (stage)
   );

   prap_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .stage   (stage),
      .take    (take),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- hw/rtl/prap_checker.sv -----
// Port-level checks of the passive reply address parser and their binding.
`include "passive_reply_address_parser_top_macros.svh"

module prap_checker
   import prap_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [BYTE_W-1:0] rx_byte,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [ADDR_W-1:0] host_addr,
   input logic [PORT_W-1:0] data_port,
   input logic              out_of_range
);

   // Reset empties the result register
   `PRAP_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset |=> !rsp_valid, "rsp valid after reset")

   // A stalled result beat keeps its payload
   `PRAP_ASSERT_ACTIVE(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(host_addr) && $stable(data_port) && $stable(out_of_range), "stalled rsp beat changed")

   // Back pressure on the input only comes from a waiting result
   `PRAP_ASSERT_ACTIVE(a_ready_needs_rsp, clock, reset, !req_ready |-> rsp_valid, "req stalled without pending rsp")

   // A fresh result follows an accepted newline beat
   `PRAP_ASSERT_ACTIVE(a_rsp_from_newline, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && (rx_byte == CHAR_NEWLINE), 2), "rsp without newline beat")

endmodule

bind passive_reply_address_parser_top prap_checker u_prap_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rx_byte      (req_bus.rx_byte),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .host_addr    (rsp_bus.host_addr),
   .data_port    (rsp_bus.data_port),
   .out_of_range (rsp_bus.out_of_range)
);
